// ===== src/pca_pkg.sv =====
// Shared constants, codes and types of the pool capacity allocator.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package pca_pkg;

	localparam int POOL_SLOTS   = 16;
	localparam int RECORD_SLOTS = 64;
	localparam int CAP_BITS     = 32;

	localparam int POOL_IDX_W = $clog2(POOL_SLOTS);
	localparam int POOL_CNT_W = $clog2(POOL_SLOTS + 1);
	localparam int REC_IDX_W  = $clog2(RECORD_SLOTS);
	localparam int REC_CNT_W  = $clog2(RECORD_SLOTS + 1);

	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 3;
	localparam int IDX_OUT_W = 6;
	localparam int CLASS_W   = 2;
	localparam int COUNT_W   = 32;

	// commands
	localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_DELETE  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_ALLOC   = 2'd2;
	localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd3;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_POOL    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_POOLS_FULL  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_CAPACITY = 3'd3;
	localparam logic [STATUS_W-1:0] ST_RECS_FULL   = 3'd4;
	localparam logic [STATUS_W-1:0] ST_BAD_RECORD  = 3'd5;
	localparam logic [STATUS_W-1:0] ST_REC_DEAD    = 3'd6;

	// pool classes
	localparam logic [CLASS_W-1:0] CLS_IDLE    = 2'd0;
	localparam logic [CLASS_W-1:0] CLS_ALLOC   = 2'd1;
	localparam logic [CLASS_W-1:0] CLS_OPTIMAL = 2'd2;
	localparam logic [CLASS_W-1:0] CLS_OVER    = 2'd3;

	typedef struct packed {
		logic                  live;
		logic [POOL_IDX_W-1:0] pool;
		logic [CAP_BITS-1:0]   amt;
	} rec_word_t;

endpackage

// ===== src/pca_req_if.sv =====
// Command channel of the pool capacity allocator: valid/ready plus command payload.
// Depends on pca_pkg.
`timescale 1ns / 1ps

interface pca_req_if
	import pca_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic [CMD_W-1:0]      cmd;
	logic [POOL_IDX_W-1:0] pool_index;
	logic [CAP_BITS-1:0]   amount;
	logic [REC_IDX_W-1:0]  record_index;

	modport source (output valid, cmd, pool_index, amount, record_index, input ready);
	modport sink (input valid, cmd, pool_index, amount, record_index, output ready);
endinterface

// ===== src/pca_rsp_if.sv =====
// Result channel of the pool capacity allocator: valid/ready plus result payload.
// Depends on pca_pkg.
`timescale 1ns / 1ps

interface pca_rsp_if
	import pca_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [STATUS_W-1:0]  status;
	logic [IDX_OUT_W-1:0] result_index;
	logic [CLASS_W-1:0]   pool_class;
	logic [CAP_BITS-1:0]  pool_available;
	logic [COUNT_W-1:0]   grant_count;
	logic [COUNT_W-1:0]   refusal_count;

	modport source (output valid, status, result_index, pool_class, pool_available,
		grant_count, refusal_count, input ready);
	modport sink (input valid, status, result_index, pool_class, pool_available,
		grant_count, refusal_count, output ready);
endinterface

// ===== src/pool_capacity_allocator_top.sv =====
// Pool capacity allocator: pool table in flops, allocation records in a memory.
// Depends on pca_pkg, pca_req_if, pca_rsp_if.
//
//  channel | modport | moves
//  --------+---------+---------------------------------------------
//  req     | sink    | one command per transfer
//  rsp     | source  | one result per command, in command order
//
// The command and its record read register in stage 1, the pool
// read-modify-write and all checks run in stage 1 and land in the result
// register. One command per cycle sustained while results are taken. A record
// written by one command and read by the next is forwarded. Reset clears
// counters and valids only; tables need no clearing. A stalled result holds
// stage 1, and req.ready drops once stage 1 is full and held.
`timescale 1ns / 1ps

module pool_capacity_allocator_top
	import pca_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	pca_req_if.sink      req,
	pca_rsp_if.source    rsp
);

	// pool table
	logic [CAP_BITS-1:0] pool_total_q [POOL_SLOTS];
	logic [CAP_BITS-1:0] pool_used_q  [POOL_SLOTS];
	logic [CAP_BITS-1:0] pool_free_q  [POOL_SLOTS];
	logic [CLASS_W-1:0]  pool_class_q [POOL_SLOTS];

	logic [POOL_CNT_W-1:0] pools_made_q;
	logic [REC_CNT_W-1:0]  records_made_q;
	logic [COUNT_W-1:0]    grants_q;
	logic [COUNT_W-1:0]    refusals_q;

	// record memory
	rec_word_t rec_mem [RECORD_SLOTS];

	// stage 1
	logic                  valid_s1;
	logic [CMD_W-1:0]      cmd_s1;
	logic [POOL_IDX_W-1:0] pidx_s1;
	logic [CAP_BITS-1:0]   amt_s1;
	logic [REC_IDX_W-1:0]  ridx_s1;
	rec_word_t             rec_rd_s1;
	logic                  byp_s1;
	rec_word_t             byp_data_s1;

	// result register
	logic                 rsp_valid_q;
	logic [STATUS_W-1:0]  status_q;
	logic [IDX_OUT_W-1:0] result_index_q;
	logic [CLASS_W-1:0]   pool_class_out_q;
	logic [CAP_BITS-1:0]  pool_avail_q;
	logic [COUNT_W-1:0]   grant_count_q;
	logic [COUNT_W-1:0]   refusal_count_q;

	logic req_fire;
	logic s1_fire;

	assign s1_fire  = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || s1_fire;
	assign req_fire = req.valid && req.ready;

	// stage 1 datapath
	rec_word_t             rec;
	logic [POOL_IDX_W-1:0] psel;
	logic [CAP_BITS-1:0]   p_total;
	logic [CAP_BITS-1:0]   p_used;
	logic [CAP_BITS-1:0]   p_free;
	logic [CLASS_W-1:0]    p_class;
	logic                  pool_ok;
	logic                  pool_room;
	logic                  rec_ok;
	logic                  rec_room;
	logic                  cap_ok;
	logic [CAP_BITS-1:0]   alloc_used;
	logic [CAP_BITS-1:0]   alloc_free;
	logic [CLASS_W-1:0]    alloc_class;
	logic [CAP_BITS-1:0]   rel_used;
	logic [CAP_BITS-1:0]   rel_free;

	logic [STATUS_W-1:0]  st_d;
	logic [IDX_OUT_W-1:0] idx_d;
	logic [CLASS_W-1:0]   cls_d;
	logic [CAP_BITS-1:0]  avail_d;
	logic                 pool_create_we;
	logic                 pool_upd_we;
	logic [CAP_BITS-1:0]  upd_used;
	logic [CAP_BITS-1:0]  upd_free;
	logic                 upd_class_we;
	logic                 rec_we;
	logic [REC_IDX_W-1:0] rec_waddr;
	rec_word_t            rec_wdata;
	logic                 grant_inc;
	logic                 refuse_inc;
	logic [COUNT_W-1:0]   grants_d;
	logic [COUNT_W-1:0]   refusals_d;

	assign rec     = byp_s1 ? byp_data_s1 : rec_rd_s1;
	assign psel    = (cmd_s1 == CMD_RELEASE) ? rec.pool : pidx_s1;
	assign p_total = pool_total_q[psel];
	assign p_used  = pool_used_q[psel];
	assign p_free  = pool_free_q[psel];
	assign p_class = pool_class_q[psel];

	assign pool_ok   = POOL_CNT_W'(pidx_s1) < pools_made_q;
	assign pool_room = pools_made_q < POOL_CNT_W'(POOL_SLOTS);
	assign rec_ok    = REC_CNT_W'(ridx_s1) < records_made_q;
	assign rec_room  = records_made_q < REC_CNT_W'(RECORD_SLOTS);
	assign cap_ok    = !(p_free < amt_s1);

	assign alloc_used = p_used + amt_s1;
	assign alloc_free = p_free - amt_s1;
	assign rel_used   = p_used - rec.amt;
	assign rel_free   = p_free + rec.amt;

	always_comb begin
		if (alloc_free < (p_total >> 2)) begin
			alloc_class = CLS_OVER;
		end else if (alloc_used > (p_total >> 1)) begin
			alloc_class = CLS_OPTIMAL;
		end else begin
			alloc_class = CLS_ALLOC;
		end
	end

	always_comb begin
		st_d           = ST_OK;
		idx_d          = '0;
		cls_d          = CLS_IDLE;
		avail_d        = '0;
		pool_create_we = 1'b0;
		pool_upd_we    = 1'b0;
		upd_used       = alloc_used;
		upd_free       = alloc_free;
		upd_class_we   = 1'b0;
		rec_we         = 1'b0;
		rec_waddr      = records_made_q[REC_IDX_W-1:0];
		rec_wdata      = '{live: 1'b1, pool: pidx_s1, amt: amt_s1};
		grant_inc      = 1'b0;
		refuse_inc     = 1'b0;
		unique case (cmd_s1)
			CMD_CREATE: begin
				if (!pool_room) begin
					st_d = ST_POOLS_FULL;
				end else begin
					pool_create_we = 1'b1;
					idx_d          = IDX_OUT_W'(pools_made_q);
					avail_d        = amt_s1;
				end
			end
			CMD_DELETE: begin
				// the pool table has no live flag, so a delete only reports
				if (!pool_ok) begin
					st_d = ST_BAD_POOL;
				end else begin
					cls_d   = p_class;
					avail_d = p_free;
				end
			end
			CMD_ALLOC: begin
				priority if (!pool_ok) begin
					st_d = ST_BAD_POOL;
				end else if (!cap_ok) begin
					st_d       = ST_NO_CAPACITY;
					cls_d      = p_class;
					avail_d    = p_free;
					refuse_inc = 1'b1;
				end else if (!rec_room) begin
					st_d       = ST_RECS_FULL;
					cls_d      = p_class;
					avail_d    = p_free;
					refuse_inc = 1'b1;
				end else begin
					pool_upd_we  = 1'b1;
					upd_class_we = 1'b1;
					rec_we       = 1'b1;
					grant_inc    = 1'b1;
					idx_d        = IDX_OUT_W'(records_made_q);
					cls_d        = alloc_class;
					avail_d      = alloc_free;
				end
			end
			CMD_RELEASE: begin
				priority if (!rec_ok) begin
					st_d = ST_BAD_RECORD;
				end else if (!rec.live) begin
					st_d = ST_REC_DEAD;
				end else begin
					pool_upd_we = 1'b1;
					upd_used    = rel_used;
					upd_free    = rel_free;
					rec_we      = 1'b1;
					rec_waddr   = ridx_s1;
					rec_wdata   = '{live: 1'b0, pool: rec.pool, amt: rec.amt};
					cls_d       = p_class;
					avail_d     = rel_free;
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign grants_d   = grants_q + COUNT_W'(grant_inc);
	assign refusals_d = refusals_q + COUNT_W'(refuse_inc);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			rsp_valid_q    <= 1'b0;
			pools_made_q   <= '0;
			records_made_q <= '0;
			grants_q       <= '0;
			refusals_q     <= '0;
		end else begin
			if (req_fire) begin
				valid_s1 <= 1'b1;
			end else if (s1_fire) begin
				valid_s1 <= 1'b0;
			end
			if (s1_fire) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (s1_fire) begin
				pools_made_q   <= pools_made_q + POOL_CNT_W'(pool_create_we);
				records_made_q <= records_made_q + REC_CNT_W'(rec_we && cmd_s1 == CMD_ALLOC);
				grants_q       <= grants_d;
				refusals_q     <= refusals_d;
			end
		end
	end

	// stage 1 payload and forwarding of a record written at the same edge
	always_ff @(posedge clk) begin
		if (req_fire) begin
			cmd_s1      <= req.cmd;
			pidx_s1     <= req.pool_index;
			amt_s1      <= req.amount;
			ridx_s1     <= req.record_index;
			byp_s1      <= s1_fire && rec_we && (rec_waddr == req.record_index);
			byp_data_s1 <= rec_wdata;
		end
	end

	// record memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (s1_fire && rec_we) begin
			rec_mem[rec_waddr] <= rec_wdata;
		end
		if (req_fire) begin
			rec_rd_s1 <= rec_mem[req.record_index];
		end
	end

	// pool table
	always_ff @(posedge clk) begin
		if (s1_fire && pool_create_we) begin
			pool_total_q[pools_made_q[POOL_IDX_W-1:0]] <= amt_s1;
			pool_used_q[pools_made_q[POOL_IDX_W-1:0]]  <= '0;
			pool_free_q[pools_made_q[POOL_IDX_W-1:0]]  <= amt_s1;
			pool_class_q[pools_made_q[POOL_IDX_W-1:0]] <= CLS_IDLE;
		end else if (s1_fire && pool_upd_we) begin
			pool_used_q[psel] <= upd_used;
			pool_free_q[psel] <= upd_free;
			if (upd_class_we) begin
				pool_class_q[psel] <= alloc_class;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (s1_fire) begin
			status_q         <= st_d;
			result_index_q   <= idx_d;
			pool_class_out_q <= cls_d;
			pool_avail_q     <= avail_d;
			grant_count_q    <= grants_d;
			refusal_count_q  <= refusals_d;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = status_q;
	assign rsp.result_index   = result_index_q;
	assign rsp.pool_class     = pool_class_out_q;
	assign rsp.pool_available = pool_avail_q;
	assign rsp.grant_count    = grant_count_q;
	assign rsp.refusal_count  = refusal_count_q;

`ifndef SYNTHESIS
	a_pools_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pools_made_q <= POOL_CNT_W'(POOL_SLOTS))
		else $error("pool count past table size");

	a_recs_bound: assert property (@(posedge clk) disable iff (!arst_n)
		records_made_q <= REC_CNT_W'(RECORD_SLOTS))
		else $error("record count past table size");

	a_counters_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(grants_q) && $stable(refusals_q))
		else $error("counter moved without a command");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_fire |=> valid_s1 && $stable(cmd_s1))
		else $error("stage 1 lost a stalled command");
`endif

endmodule
